// File: rtl/core/sbpe_pkg.sv
`default_nettype none

package sbpe_pkg;

    // Codes of the action field of an input request.
    localparam logic [1:0] ACT_WRITE1 = 2'd0;
    localparam logic [1:0] ACT_WRITE2 = 2'd1;
    localparam logic [1:0] ACT_RX     = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    // Command status codes.
    localparam logic [1:0] ST_NO_RESP = 2'd0;
    localparam logic [1:0] ST_OK      = 2'd1;
    localparam logic [1:0] ST_ERR     = 2'd2;

    // Fixed frame bytes.
    localparam logic [7:0] BYTE_HEADER = 8'hFF;
    localparam logic [7:0] BYTE_LEN1   = 8'h05;
    localparam logic [7:0] BYTE_LEN2   = 8'h07;
    localparam logic [7:0] BYTE_INSTR  = 8'h03;
    localparam logic [7:0] BYTE_NO_ERR = 8'h00;

    // Reply parser phases.
    typedef enum logic [2:0] {
        PH_HDR1 = 3'd0,
        PH_HDR2 = 3'd1,
        PH_ID   = 3'd2,
        PH_LEN  = 3'd3,
        PH_ERR  = 3'd4
    } t_phase;

    // Kind of work handed from the front to the back.
    typedef enum logic [1:0] {
        KIND_WRITE1 = 2'd0,
        KIND_WRITE2 = 2'd1,
        KIND_REPORT = 2'd2
    } t_kind;

    // One queued command: a frame to serialize or a status report.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  servo_id;
        logic [7:0]  table_address;
        logic [15:0] data_first;
        logic [15:0] data_second;
        logic [1:0]  status;
        logic        mismatch;
    } t_cmd;

endpackage

`default_nettype wire

// File: rtl/core/sbpe_fifo.sv
`default_nettype none

module sbpe_fifo #(
    parameter int DEPTH = 2
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire sbpe_pkg::t_cmd i_data,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_empty,
    output sbpe_pkg::t_cmd      o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);

    sbpe_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_count;
    logic           wr_en;
    logic           rd_en;

    assign o_full  = (r_count == FULL_COUNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == LAST_ADDR) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == LAST_ADDR) ? '0 : r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

// File: rtl/core/sbpe_front.sv
`default_nettype none

module sbpe_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  wire            i_q_full,
    input  wire [1:0]      i_action,
    input  wire [7:0]      i_servo_id,
    input  wire [7:0]      i_table_address,
    input  wire [15:0]     i_data_first,
    input  wire [15:0]     i_data_second,
    input  wire [7:0]      i_rx_byte,
    output logic           o_enq,
    output sbpe_pkg::t_cmd o_cmd
);

    sbpe_pkg::t_phase r_phase;
    sbpe_pkg::t_phase n_phase;
    logic [7:0]       r_last_id;
    logic [7:0]       n_last_id;
    logic [1:0]       r_status;
    logic [1:0]       n_status;
    logic             accept;
    logic             is_wr;
    logic             is_rx;
    logic             mis;

    assign accept = i_push && !i_q_full;
    assign is_wr  = (i_action == sbpe_pkg::ACT_WRITE1) || (i_action == sbpe_pkg::ACT_WRITE2);
    assign is_rx  = (i_action == sbpe_pkg::ACT_RX);

    // Parser next state.
    always_comb begin
        n_phase = r_phase;
        if (accept && is_rx) begin
            unique case (r_phase)
                sbpe_pkg::PH_HDR1: begin
                    if (i_rx_byte == sbpe_pkg::BYTE_HEADER) n_phase = sbpe_pkg::PH_HDR2;
                end
                sbpe_pkg::PH_HDR2: begin
                    if (i_rx_byte == sbpe_pkg::BYTE_HEADER) n_phase = sbpe_pkg::PH_ID;
                end
                sbpe_pkg::PH_ID: begin
                    n_phase = (i_rx_byte == r_last_id) ? sbpe_pkg::PH_LEN
                                                       : sbpe_pkg::PH_HDR1;
                end
                sbpe_pkg::PH_LEN: begin
                    n_phase = sbpe_pkg::PH_ERR;
                end
                default: begin
                    n_phase = sbpe_pkg::PH_HDR1;
                end
            endcase
        end
    end

    // Parser and sender outputs: status, last id and the mismatch flag.
    always_comb begin
        mis       = 1'b0;
        n_status  = r_status;
        n_last_id = r_last_id;
        if (accept && is_wr) begin
            n_status  = sbpe_pkg::ST_NO_RESP;
            n_last_id = i_servo_id;
        end else if (accept && is_rx) begin
            unique case (r_phase)
                sbpe_pkg::PH_ID: begin
                    mis = (i_rx_byte != r_last_id);
                end
                sbpe_pkg::PH_ERR: begin
                    n_status = (i_rx_byte == sbpe_pkg::BYTE_NO_ERR) ? sbpe_pkg::ST_OK
                                                                    : sbpe_pkg::ST_ERR;
                end
                default: begin
                    mis = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        unique case (i_action)
            sbpe_pkg::ACT_WRITE1: o_cmd.kind = sbpe_pkg::KIND_WRITE1;
            sbpe_pkg::ACT_WRITE2: o_cmd.kind = sbpe_pkg::KIND_WRITE2;
            default:              o_cmd.kind = sbpe_pkg::KIND_REPORT;
        endcase
        o_cmd.servo_id      = i_servo_id;
        o_cmd.table_address = i_table_address;
        o_cmd.data_first    = i_data_first;
        o_cmd.data_second   = i_data_second;
        o_cmd.status        = n_status;
        o_cmd.mismatch      = mis;
    end

    // The unused action code is taken and dropped.
    assign o_enq = accept && (is_wr || is_rx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= sbpe_pkg::PH_HDR1;
            r_last_id <= '0;
            r_status  <= sbpe_pkg::ST_NO_RESP;
        end else begin
            r_phase   <= n_phase;
            r_last_id <= n_last_id;
            r_status  <= n_status;
        end
    end

`ifndef ASSERT_OFF
    a_send_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_wr) |=> (r_status == sbpe_pkg::ST_NO_RESP && r_last_id == $past(i_servo_id)))
        else $error("send did not clear status or store id");
    a_mis_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_enq && mis) |=> (r_phase == sbpe_pkg::PH_HDR1))
        else $error("id mismatch did not restart the parser");
`endif

endmodule

`default_nettype wire

// File: rtl/core/sbpe_back.sv
`default_nettype none

module sbpe_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_empty,
    input  wire sbpe_pkg::t_cmd i_q_data,
    output logic                o_q_pop,
    output logic                o_empty,
    input  wire                 i_pop,
    output logic                o_is_tx,
    output logic [7:0]          o_tx_byte,
    output logic                o_frame_last,
    output logic [1:0]          o_cmd_status,
    output logic                o_id_mismatch
);

    // Byte positions within a frame.
    localparam logic [3:0] IDX_HDR1   = 4'd0;
    localparam logic [3:0] IDX_HDR2   = 4'd1;
    localparam logic [3:0] IDX_ID     = 4'd2;
    localparam logic [3:0] IDX_LEN    = 4'd3;
    localparam logic [3:0] IDX_INSTR  = 4'd4;
    localparam logic [3:0] IDX_ADDR   = 4'd5;
    localparam logic [3:0] IDX_D1_LO  = 4'd6;
    localparam logic [3:0] IDX_D1_HI  = 4'd7;
    localparam logic [3:0] IDX_D2_LO  = 4'd8;
    localparam logic [3:0] IDX_D2_HI  = 4'd9;
    localparam logic [3:0] IDX_CKSUM2 = 4'd10;

    sbpe_pkg::t_cmd r_cur;
    logic           r_busy;
    logic [3:0]     r_idx;
    logic [7:0]     r_sum;
    logic           r_out_valid;
    logic [3:0]     last_idx;
    logic [7:0]     cur_byte;
    logic           is_frame;
    logic           out_free;
    logic           advance;
    logic           done;
    logic           load;

    assign is_frame = (r_cur.kind != sbpe_pkg::KIND_REPORT);

    always_comb begin
        case (r_cur.kind)
            sbpe_pkg::KIND_WRITE1: last_idx = IDX_D2_LO;
            sbpe_pkg::KIND_WRITE2: last_idx = IDX_CKSUM2;
            default:               last_idx = IDX_HDR1;
        endcase
    end

    always_comb begin
        cur_byte = '0;
        if (is_frame) begin
            if (r_idx == last_idx) begin
                cur_byte = ~r_sum;
            end else begin
                unique case (r_idx) inside
                    IDX_HDR1, IDX_HDR2: cur_byte = sbpe_pkg::BYTE_HEADER;
                    IDX_ID:    cur_byte = r_cur.servo_id;
                    IDX_LEN:   cur_byte = (r_cur.kind == sbpe_pkg::KIND_WRITE2)
                                          ? sbpe_pkg::BYTE_LEN2 : sbpe_pkg::BYTE_LEN1;
                    IDX_INSTR: cur_byte = sbpe_pkg::BYTE_INSTR;
                    IDX_ADDR:  cur_byte = r_cur.table_address;
                    IDX_D1_LO: cur_byte = r_cur.data_first[7:0];
                    IDX_D1_HI: cur_byte = r_cur.data_first[15:8];
                    IDX_D2_LO: cur_byte = r_cur.data_second[7:0];
                    IDX_D2_HI: cur_byte = r_cur.data_second[15:8];
                    default:   cur_byte = '0;
                endcase
            end
        end
    end

    assign out_free = !r_out_valid || i_pop;
    assign advance  = r_busy && out_free;
    assign done     = advance && (r_idx == last_idx);
    assign load     = !i_q_empty && (!r_busy || done);
    assign o_q_pop  = load;
    assign o_empty  = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_q_data;
            r_idx <= IDX_HDR1;
            r_sum <= '0;
        end else if (advance) begin
            r_idx <= r_idx + 1'b1;
            if (r_idx >= IDX_ID) begin
                r_sum <= r_sum + cur_byte;
            end
        end
        if (advance) begin
            o_is_tx       <= is_frame;
            o_tx_byte     <= cur_byte;
            o_frame_last  <= (r_idx == last_idx);
            o_cmd_status  <= r_cur.status;
            o_id_mismatch <= r_cur.mismatch;
        end
    end

`ifndef ASSERT_OFF
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= last_idx))
        else $error("frame byte index past the checksum");
    a_tx_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_is_tx) |->
            (o_cmd_status == sbpe_pkg::ST_NO_RESP && !o_id_mismatch))
        else $error("frame byte with a reply status");
    a_report_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_is_tx) |-> (o_frame_last && o_tx_byte == '0))
        else $error("malformed status report");
`endif

endmodule

`default_nettype wire

// File: rtl/core/servo_bus_packet_engine_unit.sv
// Servo bus packet engine: builds write-instruction frames and parses status replies.
// Input channel: a queue-like push/full port. A request is taken at a clock edge where
// push is high and full is low. Action 0 or 1 sends a one- or two-word write frame to
// servo_id; action 2 feeds one received reply byte into the parser; action 3 is taken
// and dropped with no result.
// Result channel: empty/pop. While empty is low the oldest result sits on the o_ ports
// and is taken at an edge where pop is high. A write gives 9 (one word) or 11 (two words)
// frame bytes with frame_last on the checksum; a reply byte gives one status report.
// Path: with the queue and back end idle, the first result of a request passes the queue entry,
// the back end's command register and then the output register; queued work ahead streams out first.
// Throughput: while pop keeps the output free, a frame streams one byte per cycle and reply bytes
// run at one per cycle; the byte serializer in the back end sets this.
// The front classifies requests, updates the parser, last id and status at once, and hands
// a command record to a short queue, so it keeps taking requests while a frame streams out until the queue is full.
// When pop stays low the output register holds its result, the serializer stops and the
// queue fills; full then rises until the receiver drains results.
// Reset (synchronous, active low) empties queue and output, returns the parser to waiting
// for the first header, clears the last sent id and sets the status to no response.
`default_nettype none

module servo_bus_packet_engine_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        push,
    output logic       full,
    input  wire [1:0]  i_action,
    input  wire [7:0]  i_servo_id,
    input  wire [7:0]  i_table_address,
    input  wire [15:0] i_data_first,
    input  wire [15:0] i_data_second,
    input  wire [7:0]  i_rx_byte,
    output logic       empty,
    input  wire        pop,
    output logic       o_is_tx,
    output logic [7:0] o_tx_byte,
    output logic       o_frame_last,
    output logic [1:0] o_cmd_status,
    output logic       o_id_mismatch
);

    // Command records between front and back.
    sbpe_pkg::t_cmd enq_cmd;
    sbpe_pkg::t_cmd deq_cmd;
    logic           enq;
    logic           deq;
    logic           q_empty;

    // Front end: classifies each request and keeps the reply parser state.
    sbpe_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_q_full        (full),
        .i_action        (i_action),
        .i_servo_id      (i_servo_id),
        .i_table_address (i_table_address),
        .i_data_first    (i_data_first),
        .i_data_second   (i_data_second),
        .i_rx_byte       (i_rx_byte),
        .o_enq           (enq),
        .o_cmd           (enq_cmd)
    );

    // Short queue that decouples classification from serialization.
    sbpe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (enq),
        .i_data  (enq_cmd),
        .o_full  (full),
        .i_pop   (deq),
        .o_empty (q_empty),
        .o_data  (deq_cmd)
    );

    // Back end: serializes frames with a running checksum and registers each result.
    sbpe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_data      (deq_cmd),
        .o_q_pop       (deq),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_is_tx       (o_is_tx),
        .o_tx_byte     (o_tx_byte),
        .o_frame_last  (o_frame_last),
        .o_cmd_status  (o_cmd_status),
        .o_id_mismatch (o_id_mismatch)
    );

endmodule

`default_nettype wire
